/* rtl/sia_pkg.sv */
// Shared types, operation codes and widths for the small integer ALU.
package sia_pkg;

  // Integer width of the datapath and of the operand and result fields.
  localparam int INT_W = 16;
  // One divider cell per quotient bit.
  localparam int DIV_STEPS = INT_W;
  // Bits needed for an in-range shift count.
  localparam int SH_W = $clog2(INT_W);
  // Width of the action code.
  localparam int OP_W = 5;
  // Width of the result kind.
  localparam int KIND_W = 2;

  typedef logic [INT_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_LT    = 5'd2,
    OP_GT    = 5'd3,
    OP_LE    = 5'd4,
    OP_GE    = 5'd5,
    OP_EQ    = 5'd6,
    OP_NE    = 5'd7,
    OP_MUL   = 5'd8,
    OP_QUO   = 5'd9,
    OP_REM   = 5'd10,
    OP_AND   = 5'd11,
    OP_XOR   = 5'd12,
    OP_EQ2   = 5'd13,
    OP_SHIFT = 5'd19
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INT  = 2'd0,
    KIND_BOOL = 2'd1,
    KIND_NIL  = 2'd2
  } kind_t;

  // One request as it travels down the chain of cells.
  typedef struct packed {
    kind_t kind;    // result kind for non-divide operations
    word_t value;   // integer result for non-divide operations
    logic  truth;   // comparison outcome
    logic  is_div;  // quotient or remainder request
    logic  is_rem;  // remainder rather than quotient
    logic  neg_q;   // quotient gets negated at the end
    logic  neg_r;   // remainder gets negated at the end
    logic  dz;      // divisor is zero
    word_t rem;     // partial remainder magnitude
    word_t dq;      // dividend bits still to consume, quotient bits shifted in
    word_t dvs;     // divisor magnitude
  } item_t;

endpackage

/* rtl/sia_front.sv */
// Front stage: decodes a request, computes all non-divide results, seeds the divider.
module sia_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sia_pkg::OP_W-1:0]  action,
  input  logic signed [sia_pkg::INT_W-1:0] operand_a,
  input  logic signed [sia_pkg::INT_W-1:0] operand_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sia_pkg::item_t            out_item
);

  localparam int W = sia_pkg::INT_W;

  sia_pkg::item_t item_r;
  sia_pkg::item_t item_nxt;
  logic           valid_r;

  logic [W:0]     sum;
  logic [W:0]     diff;
  logic signed [2*W-1:0] prod;
  logic           lt;
  logic           eq;
  logic [W:0]     neg_cnt;
  sia_pkg::word_t shift_val;
  sia_pkg::word_t a_mag;
  sia_pkg::word_t b_mag;
  sia_pkg::op_t   op;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Shared arithmetic for the non-divide operations.
  always_comb begin
    sum     = {operand_a[W-1], operand_a} + {operand_b[W-1], operand_b};
    diff    = {operand_a[W-1], operand_a} - {operand_b[W-1], operand_b};
    prod    = operand_a * operand_b;
    lt      = operand_a < operand_b;
    eq      = operand_a == operand_b;
    neg_cnt = -{operand_b[W-1], operand_b};
    a_mag   = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
    b_mag   = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;
  end

  // Shift: left for a positive count, arithmetic right for a negative one.
  always_comb begin
    if (operand_b[W-1]) begin
      if (neg_cnt >= (W+1)'(W)) begin
        shift_val = {W{operand_a[W-1]}};
      end else begin
        shift_val = operand_a >>> neg_cnt[sia_pkg::SH_W-1:0];
      end
    end else if (operand_b >= W'(W)) begin
      shift_val = '0;
    end else begin
      shift_val = operand_a << operand_b[sia_pkg::SH_W-1:0];
    end
  end

  // Result selection by operation code.
  always_comb begin
    op              = sia_pkg::op_t'(action);
    item_nxt        = '0;
    item_nxt.kind   = sia_pkg::KIND_INT;
    item_nxt.value  = operand_a;
    item_nxt.dq     = a_mag;
    item_nxt.dvs    = b_mag;
    item_nxt.rem    = '0;
    item_nxt.neg_q  = operand_a[W-1] ^ operand_b[W-1];
    item_nxt.neg_r  = operand_a[W-1];
    item_nxt.dz     = (operand_b == '0);
    unique case (op)
      sia_pkg::OP_ADD: begin
        if (sum[W] != sum[W-1]) item_nxt.kind = sia_pkg::KIND_NIL;
        else item_nxt.value = sum[W-1:0];
      end
      sia_pkg::OP_SUB: begin
        if (diff[W] != diff[W-1]) item_nxt.kind = sia_pkg::KIND_NIL;
        else item_nxt.value = diff[W-1:0];
      end
      sia_pkg::OP_LT: begin
        item_nxt.kind  = sia_pkg::KIND_BOOL;
        item_nxt.truth = lt;
      end
      sia_pkg::OP_GT: begin
        item_nxt.kind  = sia_pkg::KIND_BOOL;
        item_nxt.truth = !lt && !eq;
      end
      sia_pkg::OP_LE: begin
        item_nxt.kind  = sia_pkg::KIND_BOOL;
        item_nxt.truth = lt || eq;
      end
      sia_pkg::OP_GE: begin
        item_nxt.kind  = sia_pkg::KIND_BOOL;
        item_nxt.truth = !lt;
      end
      sia_pkg::OP_EQ, sia_pkg::OP_EQ2: begin
        item_nxt.kind  = sia_pkg::KIND_BOOL;
        item_nxt.truth = eq;
      end
      sia_pkg::OP_NE: begin
        item_nxt.kind  = sia_pkg::KIND_BOOL;
        item_nxt.truth = !eq;
      end
      sia_pkg::OP_MUL: begin
        // The product fits when its upper bits all match the result sign.
        if (prod[2*W-1:W-1] != {(W+1){prod[W-1]}}) item_nxt.kind = sia_pkg::KIND_NIL;
        else item_nxt.value = prod[W-1:0];
      end
      sia_pkg::OP_QUO: begin
        item_nxt.is_div = 1'b1;
      end
      sia_pkg::OP_REM: begin
        item_nxt.is_div = 1'b1;
        item_nxt.is_rem = 1'b1;
      end
      sia_pkg::OP_AND:   item_nxt.value = operand_a & operand_b;
      sia_pkg::OP_XOR:   item_nxt.value = operand_a ^ operand_b;
      sia_pkg::OP_SHIFT: item_nxt.value = shift_val;
      default:           item_nxt.value = operand_a;
    endcase
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* rtl/sia_div_cell.sv */
// One divider cell: a restoring step on the magnitudes, one quotient bit per cell.
module sia_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sia_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output sia_pkg::item_t out_item
);

  localparam int W = sia_pkg::INT_W;

  sia_pkg::item_t item_r;
  sia_pkg::item_t item_nxt;
  logic           valid_r;
  logic [W:0]     trial;
  logic [W:0]     step_diff;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Bring down the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    item_nxt  = in_item;
    trial     = {in_item.rem, in_item.dq[W-1]};
    step_diff = trial - {1'b0, in_item.dvs};
    if (!step_diff[W]) begin
      item_nxt.rem = step_diff[W-1:0];
      item_nxt.dq  = {in_item.dq[W-2:0], 1'b1};
    end else begin
      item_nxt.rem = trial[W-1:0];
      item_nxt.dq  = {in_item.dq[W-2:0], 1'b0};
    end
  end

  // Cell register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* rtl/sia_back.sv */
// Back stage: applies divide signs and range checks and holds the result register.
module sia_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sia_pkg::item_t                     in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sia_pkg::KIND_W-1:0]         result_kind,
  output logic signed [sia_pkg::INT_W-1:0]   result_value,
  output logic                               truth
);

  localparam int W = sia_pkg::INT_W;

  logic                     valid_r;
  sia_pkg::kind_t           kind_r;
  sia_pkg::word_t           value_r;
  logic                     truth_r;
  sia_pkg::kind_t           kind_nxt;
  sia_pkg::word_t           value_nxt;
  logic                     truth_nxt;
  logic [W:0]               quo_s;
  sia_pkg::word_t           rem_s;

  assign in_ready     = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign result_kind  = kind_r;
  assign result_value = value_r;
  assign truth        = truth_r;

  // Signed quotient and remainder from the magnitudes.
  always_comb begin
    quo_s = in_item.neg_q ? -{1'b0, in_item.dq} : {1'b0, in_item.dq};
    rem_s = in_item.neg_r ? -in_item.rem : in_item.rem;
  end

  // Final kind, value and truth; value and truth are zero outside their kinds.
  always_comb begin
    kind_nxt  = in_item.kind;
    value_nxt = in_item.value;
    if (in_item.is_div) begin
      kind_nxt = sia_pkg::KIND_INT;
      if (in_item.dz) begin
        kind_nxt = sia_pkg::KIND_NIL;
      end else if (in_item.is_rem) begin
        value_nxt = rem_s;
      end else if (quo_s[W] != quo_s[W-1]) begin
        kind_nxt = sia_pkg::KIND_NIL;
      end else begin
        value_nxt = quo_s[W-1:0];
      end
    end
    if (kind_nxt != sia_pkg::KIND_INT) value_nxt = '0;
    truth_nxt = (kind_nxt == sia_pkg::KIND_BOOL) && in_item.truth;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      truth_r <= truth_nxt;
    end
  end

endmodule

/* rtl/small_integer_alu_core.sv */
// Top level of the small signed integer ALU: front stage, divider cell chain, result stage.
//
// Usage: a request (in_action, in_operand_a, in_operand_b) is taken when in_valid and
// in_ready are both high. Exactly one result (out_result_kind, out_result_value,
// out_truth) follows for every request, in request order, and is taken when out_valid
// and out_ready are both high.
// Path: every request passes, from acceptance to out_valid, through one front stage,
// sixteen divider cells (one quotient bit each) and one result register. All operations
// use the same path, so results never reorder.
// Throughput: one request per cycle while out_ready is high. Each stage holds one
// request and moves it on as soon as the stage after it is empty or moving, so bubbles
// are squeezed out. When the receiver holds out_ready low, results pile up in the
// stages; in_ready drops only once every stage is full, and no request is lost.
// Reset: rst_n (synchronous, active low) empties every stage; no results are pending
// afterward and a request can be taken in the next cycle.
module small_integer_alu_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [sia_pkg::OP_W-1:0]           in_action,
  input  logic signed [sia_pkg::INT_W-1:0]   in_operand_a,
  input  logic signed [sia_pkg::INT_W-1:0]   in_operand_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sia_pkg::KIND_W-1:0]         out_result_kind,
  output logic signed [sia_pkg::INT_W-1:0]   out_result_value,
  output logic                               out_truth
);

  localparam int N = sia_pkg::DIV_STEPS;

  sia_pkg::item_t      link_item  [0:N];
  logic [N:0]          link_valid;
  logic [N:0]          link_ready;

  // Decode and non-divide operations.
  sia_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (in_action),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_item  (link_item[0])
  );

  // Chain of divider cells, one quotient bit each.
  for (genvar i = 0; i < N; i++) begin : g_cell
    sia_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_item   (link_item[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_item  (link_item[i+1])
    );
  end

  // Sign fix-up and result register.
  sia_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (link_valid[N]),
    .in_ready     (link_ready[N]),
    .in_item      (link_item[N]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (out_result_kind),
    .result_value (out_result_value),
    .truth        (out_truth)
  );

endmodule

/* bench/small_integer_alu_core_tb.sv */
// Self-checking testbench for the small signed integer ALU core with randomized handshakes.
module small_integer_alu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One result as it should leave the core.
  typedef struct packed {
    sia_pkg::kind_t kind;
    sia_pkg::word_t value;
    logic           truth;
  } alu_result_t;

  // One row of the directed table; the expected result is used only when pinned.
  typedef struct packed {
    logic [sia_pkg::OP_W-1:0] code;
    sia_pkg::word_t           opa;
    sia_pkg::word_t           opb;
    logic                     pinned;
    alu_result_t              want;
  } directed_row_t;

  localparam logic [sia_pkg::OP_W-1:0] OP_UNUSED_TOP = 5'd31;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int DRAIN_CYCLES = 40;

  localparam alu_result_t FROM_MODEL = '{sia_pkg::KIND_INT, 16'h0000, 1'b0};
  localparam alu_result_t NIL_RESULT = '{sia_pkg::KIND_NIL, 16'h0000, 1'b0};
  localparam alu_result_t BOOL_TRUE  = '{sia_pkg::KIND_BOOL, 16'h0000, 1'b1};
  localparam alu_result_t BOOL_FALSE = '{sia_pkg::KIND_BOOL, 16'h0000, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [sia_pkg::OP_W-1:0] in_action = '0;
  logic signed [sia_pkg::INT_W-1:0] in_operand_a = '0;
  logic signed [sia_pkg::INT_W-1:0] in_operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [sia_pkg::KIND_W-1:0] out_result_kind;
  logic signed [sia_pkg::INT_W-1:0] out_result_value;
  logic out_truth;

  alu_result_t pending_results [$];
  int mismatches = 0;
  int send_quiet = 0;
  int take_quiet = 0;

  sia_pkg::op_t listed_ops [15] = '{
    sia_pkg::OP_ADD, sia_pkg::OP_SUB, sia_pkg::OP_LT, sia_pkg::OP_GT, sia_pkg::OP_LE,
    sia_pkg::OP_GE, sia_pkg::OP_EQ, sia_pkg::OP_NE, sia_pkg::OP_MUL, sia_pkg::OP_QUO,
    sia_pkg::OP_REM, sia_pkg::OP_AND, sia_pkg::OP_XOR, sia_pkg::OP_EQ2, sia_pkg::OP_SHIFT};

  // Corners of every operation: overflow, zero divisor, minimum over minus one,
  // the duplicate equality code, an unlisted code and the shift limits.
  directed_row_t directed_rows [26] = '{
    '{sia_pkg::OP_ADD,   16'h7fff, 16'h0001, 1'b1, NIL_RESULT},
    '{sia_pkg::OP_ADD,   16'h7fff, 16'h8000, 1'b1, '{sia_pkg::KIND_INT, 16'hffff, 1'b0}},
    '{sia_pkg::OP_SUB,   16'h8000, 16'h0001, 1'b1, NIL_RESULT},
    '{sia_pkg::OP_LT,    16'h8000, 16'h7fff, 1'b1, BOOL_TRUE},
    '{sia_pkg::OP_GT,    16'h8000, 16'h7fff, 1'b1, BOOL_FALSE},
    '{sia_pkg::OP_LE,    16'h7fff, 16'h7fff, 1'b1, BOOL_TRUE},
    '{sia_pkg::OP_GE,    16'h8000, 16'h7fff, 1'b1, BOOL_FALSE},
    '{sia_pkg::OP_EQ,    16'h1234, 16'h1234, 1'b1, BOOL_TRUE},
    '{sia_pkg::OP_NE,    16'h1234, 16'h1234, 1'b1, BOOL_FALSE},
    '{sia_pkg::OP_MUL,   16'h0100, 16'h0100, 1'b1, NIL_RESULT},
    '{sia_pkg::OP_MUL,   16'h8000, 16'hffff, 1'b1, NIL_RESULT},
    '{sia_pkg::OP_MUL,   16'hff00, 16'h0080, 1'b1, '{sia_pkg::KIND_INT, 16'h8000, 1'b0}},
    '{sia_pkg::OP_QUO,   16'h1234, 16'h0000, 1'b1, NIL_RESULT},
    '{sia_pkg::OP_REM,   16'h1234, 16'h0000, 1'b1, NIL_RESULT},
    '{sia_pkg::OP_QUO,   16'h8000, 16'hffff, 1'b1, NIL_RESULT},
    '{sia_pkg::OP_REM,   16'h8000, 16'hffff, 1'b1, '{sia_pkg::KIND_INT, 16'h0000, 1'b0}},
    '{sia_pkg::OP_QUO,   16'hfff9, 16'h0002, 1'b0, FROM_MODEL},
    '{sia_pkg::OP_REM,   16'hfff9, 16'h0002, 1'b0, FROM_MODEL},
    '{sia_pkg::OP_AND,   16'hff0f, 16'h1234, 1'b0, FROM_MODEL},
    '{sia_pkg::OP_XOR,   16'hff0f, 16'h1234, 1'b0, FROM_MODEL},
    '{sia_pkg::OP_EQ2,   16'h8000, 16'h8000, 1'b1, BOOL_TRUE},
    '{OP_UNUSED_TOP,     16'h5a5a, 16'hffff, 1'b1, '{sia_pkg::KIND_INT, 16'h5a5a, 1'b0}},
    '{sia_pkg::OP_SHIFT, 16'h0001, 16'h000f, 1'b1, '{sia_pkg::KIND_INT, 16'h8000, 1'b0}},
    '{sia_pkg::OP_SHIFT, 16'h0003, 16'h0010, 1'b1, '{sia_pkg::KIND_INT, 16'h0000, 1'b0}},
    '{sia_pkg::OP_SHIFT, 16'h8000, 16'hfff0, 1'b1, '{sia_pkg::KIND_INT, 16'hffff, 1'b0}},
    '{sia_pkg::OP_SHIFT, 16'h8001, 16'hfffc, 1'b0, FROM_MODEL}
  };

  small_integer_alu_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value),
    .out_truth        (out_truth)
  );

  // A 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Computes the result of one request from the operation code and both operands.
  function automatic alu_result_t alu_outcome(logic [sia_pkg::OP_W-1:0] code,
                                              sia_pkg::word_t opa, sia_pkg::word_t opb);
    longint a, b, r, hi, lo, n;
    alu_result_t res;
    a = longint'(signed'(opa));
    b = longint'(signed'(opb));
    hi = (longint'(1) << (sia_pkg::INT_W - 1)) - 1;
    lo = -hi - 1;
    res = '{sia_pkg::KIND_INT, opa, 1'b0};
    case (code)
      sia_pkg::OP_ADD, sia_pkg::OP_SUB, sia_pkg::OP_MUL: begin
        r = (code == sia_pkg::OP_ADD) ? a + b : (code == sia_pkg::OP_SUB) ? a - b : a * b;
        if (r >= lo && r <= hi) res.value = sia_pkg::word_t'(r);
        else res.kind = sia_pkg::KIND_NIL;
      end
      sia_pkg::OP_LT: begin res.kind = sia_pkg::KIND_BOOL; res.truth = (a < b); end
      sia_pkg::OP_GT: begin res.kind = sia_pkg::KIND_BOOL; res.truth = (a > b); end
      sia_pkg::OP_LE: begin res.kind = sia_pkg::KIND_BOOL; res.truth = (a <= b); end
      sia_pkg::OP_GE: begin res.kind = sia_pkg::KIND_BOOL; res.truth = (a >= b); end
      sia_pkg::OP_EQ, sia_pkg::OP_EQ2: begin
        res.kind = sia_pkg::KIND_BOOL;
        res.truth = (a == b);
      end
      sia_pkg::OP_NE: begin res.kind = sia_pkg::KIND_BOOL; res.truth = (a != b); end
      sia_pkg::OP_QUO: begin
        // Division truncates toward zero; the quotient of minimum by minus one overflows.
        if (b == 0) begin
          res.kind = sia_pkg::KIND_NIL;
        end else begin
          r = a / b;
          if (r >= lo && r <= hi) res.value = sia_pkg::word_t'(r);
          else res.kind = sia_pkg::KIND_NIL;
        end
      end
      sia_pkg::OP_REM: begin
        if (b == 0) res.kind = sia_pkg::KIND_NIL;
        else res.value = sia_pkg::word_t'(a % b);
      end
      sia_pkg::OP_AND: res.value = opa & opb;
      sia_pkg::OP_XOR: res.value = opa ^ opb;
      sia_pkg::OP_SHIFT: begin
        // A negative count shifts right arithmetically, a positive one left with wrap.
        if (b < 0) begin
          n = -b;
          if (n >= sia_pkg::INT_W) res.value = (a < 0) ? '1 : '0;
          else res.value = sia_pkg::word_t'(a >>> n);
        end else if (b >= sia_pkg::INT_W) begin
          res.value = '0;
        end else begin
          res.value = sia_pkg::word_t'(a << b);
        end
      end
      default: ;
    endcase
    if (res.kind != sia_pkg::KIND_INT) res.value = '0;
    return res;
  endfunction

  // Idle cycles before the next request, with occasional runs of back-to-back traffic.
  function automatic int idle_cycles(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Operands lean toward the range limits and small values, which hit the shift limits.
  function automatic sia_pkg::word_t pick_operand();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      1, 2: return sia_pkg::word_t'($urandom_range(0, 40) - 20);
      default: return sia_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic logic [sia_pkg::OP_W-1:0] pick_code();
    if ($urandom_range(0, 9) == 0) return (sia_pkg::OP_W)'($urandom);
    return listed_ops[$urandom_range(0, 14)];
  endfunction

  // Presents one request, waits for its acceptance and records the result it must give.
  task automatic send_request(input logic [sia_pkg::OP_W-1:0] code,
                              input sia_pkg::word_t opa, input sia_pkg::word_t opb,
                              input logic pinned, input alu_result_t want);
    int gap;
    gap = idle_cycles(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= code;
    in_operand_a <= opa;
    in_operand_b <= opb;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back(pinned ? want : alu_outcome(code, opa, opb));
  endtask

  // Stimulus: reset, the directed table, then random requests, then the drain.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].code, directed_rows[i].opa, directed_rows[i].opb,
                   directed_rows[i].pinned, directed_rows[i].want);
    end
    repeat (RANDOM_REQUESTS) begin
      send_request(pick_code(), pick_operand(), pick_operand(), 1'b0, FROM_MODEL);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("small_integer_alu_core: match");
    end else begin
      $display("small_integer_alu_core: mismatch");
    end
    $finish;
  end

  // Receiver: stalls at random, then compares each result with the oldest expectation.
  initial begin
    alu_result_t want;
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_cycles(take_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("result arrived with no request waiting for it");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
          mismatches++;
        end
        if (out_result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", signed'(want.value), out_result_value);
          mismatches++;
        end
        if (out_truth !== want.truth) begin
          $error("truth: expected %0b, got %0b", want.truth, out_truth);
          mismatches++;
        end
      end
    end
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("small_integer_alu_core: mismatch");
    $finish;
  end

endmodule

/* small_integer_alu_core.f */
rtl/sia_pkg.sv
rtl/sia_front.sv
rtl/sia_div_cell.sv
rtl/sia_back.sv
rtl/small_integer_alu_core.sv
bench/small_integer_alu_core_tb.sv
